>>> src/wstl_pkg.sv
// ----------------------------------------------------------------------------
// wstl_pkg
// Shared widths, constants and types for the wheel slip traction limiter.
// ----------------------------------------------------------------------------
`default_nettype none

package wstl_pkg;

	// field widths
	localparam int SPEED_BITS = 16;
	localparam int TIME_BITS  = 31;
	localparam int CFG_W      = 16;
	localparam int SLIP_W     = 16;
	localparam int SCALE_W    = 16;
	localparam int IDX_W      = 2;

	// slip divide: (rmax << SLIP_SHIFT) / (fl + fr)
	localparam int SLIP_SHIFT = 9;
	localparam int SUM_W      = SPEED_BITS + 1;
	localparam int DVD_W      = SPEED_BITS + SLIP_SHIFT;
	localparam int REM_W      = (SUM_W > CFG_W) ? SUM_W : CFG_W;
	localparam int STEP_W     = $clog2(DVD_W + 1);

	// ramp divide: (n << SCALE_FRAC) / ramp_ms, n < ramp_ms
	localparam int SCALE_FRAC = SCALE_W - 1;

	// signed ramp time base and elapsed time
	localparam int N_W = TIME_BITS + 2;

	localparam int SLIP_BIAS  = 256;
	localparam int SLIP_MAX   = 65535;
	localparam int FULL_SCALE = 32768;

	localparam int TARGET_RST = 26;
	localparam int RAMP_RST   = 500;
	localparam int HOLD_RST   = 50;

	// stream packing
	localparam int IN_W     = 4 * SPEED_BITS + TIME_BITS;
	localparam int IN_TD_W  = ((IN_W + 7) / 8) * 8;
	localparam int OUT_W    = SCALE_W + SLIP_W + 2;
	localparam int OUT_TD_W = ((OUT_W + 7) / 8) * 8;

	typedef enum logic [IDX_W-1:0] {
		CFG_TARGET_SLIP = 2'd0,
		CFG_RAMP_MS     = 2'd1,
		CFG_HOLD_MS     = 2'd2
	} cfg_idx_t;

	typedef struct packed {
		logic              start;
		logic [REM_W-1:0]  rem_init;
		logic [DVD_W-1:0]  dvd;
		logic [REM_W-1:0]  divisor;
		logic [STEP_W-1:0] steps;
	} div_cmd_t;

	typedef struct packed {
		logic             done;
		logic [DVD_W-1:0] quo;
	} div_rsp_t;

endpackage

`default_nettype wire

>>> src/wheel_slip_traction_limiter.sv
// ----------------------------------------------------------------------------
// wheel_slip_traction_limiter
// Slip estimate and torque cut / ramp from four wheel speeds per sample.
// ----------------------------------------------------------------------------
// Input words arrive on s_tvalid/s_tready/s_tdata, one sample each; one result
// word per sample leaves on m_tvalid/m_tready/m_tdata. Registers are written
// through cfg_we/cfg_index/cfg_wdata; the user must write them only while no
// sample is in flight; the block does not enforce it. A sample runs through
// one shared bit-serial divider: slip takes 25 steps, the ramp fraction 15
// steps, and either is skipped when the answer is known (front sum zero, ramp
// finished or not started). s_tready is high only while the sequencer is idle,
// so the next word can be taken at the earliest in the cycle after the previous
// result is loaded. The result sits in an output register; a stalled
// receiver only holds the sequencer in its final state, and a new sample can
// be accepted while the last result still waits.
// Reset clears the slip flag and hold timer, puts the ramp as finished and
// loads the register defaults (target 26, ramp 500 ms, hold 50 ms).
// ----------------------------------------------------------------------------
`default_nettype none

module wheel_slip_traction_limiter
	import wstl_pkg::*;
(
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                s_tvalid,
	output logic                     s_tready,
	// fl_speed, fr_speed, rl_speed, rr_speed, time_ms, zero fill
	input  wire logic [IN_TD_W-1:0]  s_tdata,
	output logic                     m_tvalid,
	input  wire logic                m_tready,
	// torque_scale, slip, slipping, front_zero, zero fill
	output logic [OUT_TD_W-1:0]      m_tdata,
	input  wire logic                cfg_we,
	input  wire logic [IDX_W-1:0]    cfg_index,
	input  wire logic [CFG_W-1:0]    cfg_wdata
);

	typedef enum logic [5:0] {
		ST_IDLE = 6'b000001,
		ST_PREP = 6'b000010,
		ST_SLIP = 6'b000100,
		ST_RCHK = 6'b001000,
		ST_RAMP = 6'b010000,
		ST_FIN  = 6'b100000
	} state_t;

	state_t state_q;

	logic [CFG_W-1:0] target_q;
	logic [CFG_W-1:0] ramp_ms_q;
	logic [CFG_W-1:0] hold_ms_q;

	logic                  flag_q;
	logic [TIME_BITS-1:0]  fct_q;
	logic signed [N_W-1:0] ramp_start_q;

	logic [SPEED_BITS-1:0] fl_q, fr_q, rl_q, rr_q;
	logic [TIME_BITS-1:0]  now_q;
	logic [N_W-1:0]        n_q;
	logic [SLIP_W-1:0]     slip_q;
	logic                  zero_q;
	logic                  slipping_q;
	logic [SCALE_W-1:0]    scale_q;

	logic                  m_tvalid_q;
	logic [OUT_TD_W-1:0]   m_tdata_q;

	div_cmd_t div_cmd;
	div_rsp_t div_rsp;

	logic                  accept;
	logic [SUM_W-1:0]      sum;
	logic [SPEED_BITS-1:0] rmax;
	logic [N_W-1:0]        n_now;
	logic                  ramp_full;
	logic                  ramp_none;
	logic [DVD_W-1:0]      q_unb;
	logic [SLIP_W-1:0]     slip_div;
	logic                  chg;
	logic [TIME_BITS:0]    held_raw;
	logic                  held_ok;
	logic                  cut;
	logic                  out_free;
	logic                  load_out;

	wstl_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (div_cmd),
		.rsp    (div_rsp)
	);

	always_comb begin
		accept    = s_tvalid && s_tready;
		sum       = SUM_W'(fl_q) + SUM_W'(fr_q);
		rmax      = (rl_q > rr_q) ? rl_q : rr_q;
		n_now     = N_W'(now_q) - ramp_start_q;
		ramp_full = !n_q[N_W-1] && (n_q[N_W-2:0] >= (N_W-1)'(ramp_ms_q));
		ramp_none = n_q[N_W-1] || (n_q == '0);

		// slip = quotient - 1.0, floored at zero, saturated
		q_unb = div_rsp.quo - DVD_W'(SLIP_BIAS);
		if (div_rsp.quo <= DVD_W'(SLIP_BIAS))
			slip_div = '0;
		else if (q_unb > DVD_W'(SLIP_MAX))
			slip_div = SLIP_W'(SLIP_MAX);
		else
			slip_div = q_unb[SLIP_W-1:0];

		// hold timer; a fresh change of flag means zero elapsed time
		chg      = slipping_q != flag_q;
		held_raw = {1'b0, now_q} - {1'b0, fct_q};
		if (chg || held_raw[TIME_BITS])
			held_ok = hold_ms_q == '0;
		else
			held_ok = held_raw[TIME_BITS-1:0] >= TIME_BITS'(hold_ms_q);
		cut = slipping_q && held_ok;

		out_free = !m_tvalid_q || m_tready;
		load_out = (state_q == ST_FIN) && out_free;
	end

	always_comb begin
		div_cmd = '0;
		if (state_q == ST_PREP && sum != '0) begin
			div_cmd.start    = 1'b1;
			div_cmd.rem_init = '0;
			div_cmd.dvd      = {rmax, SLIP_SHIFT'(0)};
			div_cmd.divisor  = REM_W'(sum);
			div_cmd.steps    = STEP_W'(DVD_W);
		end else if (state_q == ST_RCHK && !ramp_full && !ramp_none) begin
			div_cmd.start    = 1'b1;
			div_cmd.rem_init = REM_W'(n_q[CFG_W-1:0]);
			div_cmd.dvd      = '0;
			div_cmd.divisor  = REM_W'(ramp_ms_q);
			div_cmd.steps    = STEP_W'(SCALE_FRAC);
		end
	end

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			target_q  <= CFG_W'(TARGET_RST);
			ramp_ms_q <= CFG_W'(RAMP_RST);
			hold_ms_q <= CFG_W'(HOLD_RST);
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_TARGET_SLIP: target_q  <= cfg_wdata;
				CFG_RAMP_MS:     ramp_ms_q <= cfg_wdata;
				CFG_HOLD_MS:     hold_ms_q <= cfg_wdata;
				default: ;
			endcase
		end
	end

	// sequencer and traction state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			flag_q       <= 1'b0;
			fct_q        <= '0;
			ramp_start_q <= -N_W'(RAMP_RST);
			m_tvalid_q   <= 1'b0;
		end else begin
			if (load_out)
				m_tvalid_q <= 1'b1;
			else if (m_tready)
				m_tvalid_q <= 1'b0;

			unique case (state_q)
				ST_IDLE: begin
					if (accept)
						state_q <= ST_PREP;
				end
				ST_PREP: begin
					state_q <= (sum == '0) ? ST_RCHK : ST_SLIP;
				end
				ST_SLIP: begin
					if (div_rsp.done)
						state_q <= ST_RCHK;
				end
				ST_RCHK: begin
					state_q <= (ramp_full || ramp_none) ? ST_FIN : ST_RAMP;
				end
				ST_RAMP: begin
					if (div_rsp.done)
						state_q <= ST_FIN;
				end
				ST_FIN: begin
					if (out_free) begin
						state_q <= ST_IDLE;
						flag_q  <= slipping_q;
						if (chg)
							fct_q <= now_q;
						if (cut)
							ramp_start_q <= N_W'(now_q);
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// sample and working registers
	always_ff @(posedge clk) begin
		if (accept) begin
			fl_q  <= s_tdata[0 +: SPEED_BITS];
			fr_q  <= s_tdata[SPEED_BITS +: SPEED_BITS];
			rl_q  <= s_tdata[2*SPEED_BITS +: SPEED_BITS];
			rr_q  <= s_tdata[3*SPEED_BITS +: SPEED_BITS];
			now_q <= s_tdata[4*SPEED_BITS +: TIME_BITS];
		end
		if (state_q == ST_PREP) begin
			n_q    <= n_now;
			zero_q <= sum == '0;
			if (sum == '0)
				slip_q <= SLIP_W'(SLIP_MAX);
		end
		if (state_q == ST_SLIP && div_rsp.done)
			slip_q <= slip_div;
		if (state_q == ST_RCHK) begin
			slipping_q <= SLIP_W'(slip_q) > SLIP_W'(target_q);
			if (ramp_full)
				scale_q <= SCALE_W'(FULL_SCALE);
			else if (ramp_none)
				scale_q <= '0;
		end
		if (state_q == ST_RAMP && div_rsp.done)
			scale_q <= SCALE_W'(div_rsp.quo[SCALE_FRAC-1:0]);
		if (load_out)
			m_tdata_q <= OUT_TD_W'({zero_q, slipping_q, slip_q,
				(cut ? SCALE_W'(0) : scale_q)});
	end

	assign s_tready = state_q == ST_IDLE;
	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;

endmodule

`default_nettype wire

>>> src/wstl_div.sv
// ----------------------------------------------------------------------------
// wstl_div
// Shared restoring divider, one quotient bit per cycle. The remainder can be
// preloaded so that a fraction (dividend bits all zero) comes out directly.
// ----------------------------------------------------------------------------
`default_nettype none

module wstl_div
	import wstl_pkg::*;
(
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire div_cmd_t cmd,
	output div_rsp_t      rsp
);

	logic              active_q;
	logic              done_q;
	logic [STEP_W-1:0] cnt_q;
	logic [REM_W-1:0]  rem_q;
	logic [REM_W-1:0]  dsr_q;
	logic [DVD_W-1:0]  sh_q;

	logic [REM_W+1:0]  trial;
	logic              ge;
	logic [REM_W-1:0]  rem_next;

	always_comb begin
		trial    = {1'b0, rem_q, sh_q[DVD_W-1]} - {2'b00, dsr_q};
		ge       = ~trial[REM_W+1];
		rem_next = ge ? trial[REM_W-1:0] : {rem_q[REM_W-2:0], sh_q[DVD_W-1]};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q <= 1'b0;
			done_q   <= 1'b0;
			cnt_q    <= '0;
		end else begin
			done_q <= 1'b0;
			if (cmd.start) begin
				active_q <= 1'b1;
				cnt_q    <= cmd.steps;
			end else if (active_q) begin
				cnt_q <= cnt_q - STEP_W'(1);
				if (cnt_q == STEP_W'(1)) begin
					active_q <= 1'b0;
					done_q   <= 1'b1;
				end
			end
		end
	end

	// quotient bits shift in at the bottom as dividend bits leave the top
	always_ff @(posedge clk) begin
		if (cmd.start) begin
			rem_q <= cmd.rem_init;
			dsr_q <= cmd.divisor;
			sh_q  <= cmd.dvd;
		end else if (active_q) begin
			rem_q <= rem_next;
			sh_q  <= {sh_q[DVD_W-2:0], ge};
		end
	end

	assign rsp.done = done_q;
	assign rsp.quo  = sh_q;

endmodule

`default_nettype wire
